### hw/rtl/vrq_pkg.sv
`default_nettype none

package vrq_pkg;

  // Input component width (Q1.30 quaternion, Q15.16 vector).
  localparam int unsigned IN_W   = 32;
  // First Hamilton product component: sum of three 64-bit products.
  localparam int unsigned PW     = 66;
  // Split of a first-product component for the second multiply.
  localparam int unsigned LOW_W  = 33;
  localparam int unsigned HI_W   = PW - LOW_W;
  // One partial product of the second multiply.
  localparam int unsigned TERM_W = 65;
  // Sum of four signed partial products.
  localparam int unsigned SUM_W  = TERM_W + 2;
  // Recombined exact second product, 76 fraction bits.
  localparam int unsigned ACC_W  = SUM_W + LOW_W;
  // Fraction bits dropped to reach Q15.16.
  localparam int unsigned DROP   = 60;
  localparam int unsigned RND_W  = ACC_W - DROP;

  localparam logic [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-DROP){1'b0}}, 1'b1, {(DROP-1){1'b0}}};

  localparam logic [IN_W-1:0] SAT_POS = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic [IN_W-1:0] SAT_NEG = {1'b1, {(IN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] r;
    logic signed [IN_W-1:0] i;
    logic signed [IN_W-1:0] j;
    logic signed [IN_W-1:0] k;
  } quat_t;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] i;
    logic signed [PW-1:0] j;
    logic signed [PW-1:0] k;
  } pquat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
  } part_t;

  typedef struct packed {
    part_t x;
    part_t y;
    part_t z;
  } parts_t;

  typedef struct packed {
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] z;
    logic            sat;
  } rot_t;

endpackage

`default_nettype wire

### hw/rtl/vrq_if.sv
`default_nettype none

interface vrq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] quat_r;
  logic [31:0] quat_i;
  logic [31:0] quat_j;
  logic [31:0] quat_k;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [31:0] vec_z;

  modport source (output valid, quat_r, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_r, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface vrq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rot_x;
  logic [31:0] rot_y;
  logic [31:0] rot_z;
  logic        saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

`default_nettype wire

### hw/rtl/vrq_ham1.sv
`default_nettype none

module vrq_ham1
  import vrq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire quat_t  in_quat,
  input  wire vec_t   in_vec,
  output logic        out_valid,
  input  wire logic   out_ready,
  output pquat_t      out_p,
  output quat_t       out_q
);

  // Product order: ix jy kz rx jz ky ry iz kx rz iy jx
  localparam int unsigned NPROD = 12;

  logic signed [2*IN_W-1:0] prod_r [NPROD];
  logic signed [2*IN_W-1:0] prod_nxt [NPROD];
  quat_t  qa_r;
  logic   va_r;
  pquat_t pb_r;
  quat_t  qb_r;
  logic   vb_r;
  logic   rdy_a;
  logic   rdy_b;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    prod_nxt[0]  = in_quat.i * in_vec.x;
    prod_nxt[1]  = in_quat.j * in_vec.y;
    prod_nxt[2]  = in_quat.k * in_vec.z;
    prod_nxt[3]  = in_quat.r * in_vec.x;
    prod_nxt[4]  = in_quat.j * in_vec.z;
    prod_nxt[5]  = in_quat.k * in_vec.y;
    prod_nxt[6]  = in_quat.r * in_vec.y;
    prod_nxt[7]  = in_quat.i * in_vec.z;
    prod_nxt[8]  = in_quat.k * in_vec.x;
    prod_nxt[9]  = in_quat.r * in_vec.z;
    prod_nxt[10] = in_quat.i * in_vec.y;
    prod_nxt[11] = in_quat.j * in_vec.x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  // Stage A: twelve products.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      for (int n = 0; n < NPROD; n++) prod_r[n] <= prod_nxt[n];
      qa_r <= in_quat;
    end
  end

  // Stage B: p = q * (0, v).
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      pb_r.r <= -(PW'(prod_r[0]) + PW'(prod_r[1]) + PW'(prod_r[2]));
      pb_r.i <= PW'(prod_r[3]) + PW'(prod_r[4]) - PW'(prod_r[5]);
      pb_r.j <= PW'(prod_r[6]) - PW'(prod_r[7]) + PW'(prod_r[8]);
      pb_r.k <= PW'(prod_r[9]) + PW'(prod_r[10]) - PW'(prod_r[11]);
      qb_r   <= qa_r;
    end
  end

  assign out_valid = vb_r;
  assign out_p     = pb_r;
  assign out_q     = qb_r;

endmodule

`default_nettype wire

### hw/rtl/vrq_ham2.sv
`default_nettype none

module vrq_ham2
  import vrq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire pquat_t in_p,
  input  wire quat_t  in_q,
  output logic        out_valid,
  input  wire logic   out_ready,
  output parts_t      out_parts
);

  // Terms of s = p * conj(q), four per output component:
  // x: +pi*r -pr*i -pj*k +pk*j
  // y: +pj*r -pr*j +pi*k -pk*i
  // z: +pk*r -pr*k -pi*j +pj*i
  localparam int unsigned NTERM = 12;

  logic signed [PW-1:0]     p_op [NTERM];
  logic signed [IN_W-1:0]   q_op [NTERM];
  logic signed [TERM_W-1:0] lo_r [NTERM];
  logic signed [TERM_W-1:0] hi_r [NTERM];
  logic                     vc_r;
  parts_t                   pd_r;
  logic                     vd_r;
  logic                     rdy_c;
  logic                     rdy_d;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign in_ready = rdy_c;

  always_comb begin
    p_op[0]  = in_p.i; q_op[0]  = in_q.r;
    p_op[1]  = in_p.r; q_op[1]  = in_q.i;
    p_op[2]  = in_p.j; q_op[2]  = in_q.k;
    p_op[3]  = in_p.k; q_op[3]  = in_q.j;
    p_op[4]  = in_p.j; q_op[4]  = in_q.r;
    p_op[5]  = in_p.r; q_op[5]  = in_q.j;
    p_op[6]  = in_p.i; q_op[6]  = in_q.k;
    p_op[7]  = in_p.k; q_op[7]  = in_q.i;
    p_op[8]  = in_p.k; q_op[8]  = in_q.r;
    p_op[9]  = in_p.r; q_op[9]  = in_q.k;
    p_op[10] = in_p.i; q_op[10] = in_q.j;
    p_op[11] = in_p.j; q_op[11] = in_q.i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= in_valid;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  // Stage C: split each p operand at LOW_W, one 33x32 multiply per half.
  // Sign-extend both operands to the term width so the product keeps its top bits.
  always_ff @(posedge clk) begin
    if (rdy_c) begin
      for (int n = 0; n < NTERM; n++) begin
        lo_r[n] <= TERM_W'($signed({1'b0, p_op[n][LOW_W-1:0]})) * TERM_W'(q_op[n]);
        hi_r[n] <= TERM_W'($signed(p_op[n][PW-1:LOW_W])) * TERM_W'(q_op[n]);
      end
    end
  end

  // Stage D: signed sums of the halves, kept apart until recombining.
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      pd_r.x.lo <= SUM_W'(lo_r[0]) - SUM_W'(lo_r[1]) - SUM_W'(lo_r[2]) + SUM_W'(lo_r[3]);
      pd_r.x.hi <= SUM_W'(hi_r[0]) - SUM_W'(hi_r[1]) - SUM_W'(hi_r[2]) + SUM_W'(hi_r[3]);
      pd_r.y.lo <= SUM_W'(lo_r[4]) - SUM_W'(lo_r[5]) + SUM_W'(lo_r[6]) - SUM_W'(lo_r[7]);
      pd_r.y.hi <= SUM_W'(hi_r[4]) - SUM_W'(hi_r[5]) + SUM_W'(hi_r[6]) - SUM_W'(hi_r[7]);
      pd_r.z.lo <= SUM_W'(lo_r[8]) - SUM_W'(lo_r[9]) - SUM_W'(lo_r[10]) + SUM_W'(lo_r[11]);
      pd_r.z.hi <= SUM_W'(hi_r[8]) - SUM_W'(hi_r[9]) - SUM_W'(hi_r[10]) + SUM_W'(hi_r[11]);
    end
  end

  assign out_valid = vd_r;
  assign out_parts = pd_r;

endmodule

`default_nettype wire

### hw/rtl/vrq_round.sv
`default_nettype none

module vrq_round
  import vrq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire parts_t in_parts,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rot_t        out_rot
);

  logic [RND_W-1:0] re_r [3];
  logic [RND_W-1:0] re_nxt [3];
  logic             ve_r;
  rot_t             rf_r;
  rot_t             rf_nxt;
  logic             vf_r;
  logic             rdy_e;
  logic             rdy_f;
  logic [IN_W-1:0]  sat_val [3];
  logic [2:0]       clip;

  assign rdy_f    = !vf_r || out_ready;
  assign rdy_e    = !ve_r || rdy_f;
  assign in_ready = rdy_e;

  function automatic logic [RND_W-1:0] recombine(part_t pt);
    logic [ACC_W-1:0] acc;
    acc = (ACC_W'(pt.hi) <<< LOW_W) + ACC_W'(pt.lo) + ROUND_HALF;
    return acc[ACC_W-1:DROP];
  endfunction

  always_comb begin
    re_nxt[0] = recombine(in_parts.x);
    re_nxt[1] = recombine(in_parts.y);
    re_nxt[2] = recombine(in_parts.z);
  end

  // Clip when the bits above the Q15.16 sign do not all match it.
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      clip[n] = (re_r[n][RND_W-1:IN_W-1] != {(RND_W-IN_W+1){1'b0}}) &&
                (re_r[n][RND_W-1:IN_W-1] != {(RND_W-IN_W+1){1'b1}});
      if (clip[n]) sat_val[n] = re_r[n][RND_W-1] ? SAT_NEG : SAT_POS;
      else         sat_val[n] = re_r[n][IN_W-1:0];
    end
    rf_nxt.x   = sat_val[0];
    rf_nxt.y   = sat_val[1];
    rf_nxt.z   = sat_val[2];
    rf_nxt.sat = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_e) ve_r <= in_valid;
      if (rdy_f) vf_r <= ve_r;
    end
  end

  // Stage E: recombine, round half up, drop fraction bits.
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      for (int n = 0; n < 3; n++) re_r[n] <= re_nxt[n];
    end
  end

  // Stage F: saturate into the output register.
  always_ff @(posedge clk) begin
    if (rdy_f) rf_r <= rf_nxt;
  end

  assign out_valid = vf_r;
  assign out_rot   = rf_r;

endmodule

`default_nettype wire

### hw/rtl/vector_rotate_by_quaternion.sv
`default_nettype none

// Rotates a vector by a quaternion: rot = q * (0, v) * conj(q), vector part.
// q is not normalized, so the result also carries a scale of |q|^2.
//
// in_ch  (sink):   quat_r/i/j/k in signed Q1.30, vec_x/y/z in signed Q15.16.
// out_ch (source): rot_x/y/z in signed Q15.16, rounded half up and saturated;
//                  saturated is high when any component was clipped.
// An item moves when valid and ready are both high at a rising edge.
//
// Stages A to F lie between input accept and output valid. Throughput: one
// item per cycle while out_ch is not stalled; multiplies and adds sit apart,
// and the second Hamilton product is 33x32 partial products summed later.
// Each of the six stages has its own valid bit and advances when it is empty
// or its successor does, so bubbles close up under a stall and input stays
// ready until the whole pipe is full behind a waiting result.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// not reset. A stalled receiver holds out_ch steady until it takes the item.
module vector_rotate_by_quaternion
  import vrq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  vrq_in_if.sink    in_ch,
  vrq_out_if.source out_ch
);

  quat_t  in_quat;
  vec_t   in_vec;
  logic   h1_valid;
  logic   h1_ready;
  pquat_t h1_p;
  quat_t  h1_q;
  logic   h2_valid;
  logic   h2_ready;
  parts_t h2_parts;
  rot_t   rot;

  // Gather the channel payload into structs.
  assign in_quat.r = in_ch.quat_r;
  assign in_quat.i = in_ch.quat_i;
  assign in_quat.j = in_ch.quat_j;
  assign in_quat.k = in_ch.quat_k;
  assign in_vec.x  = in_ch.vec_x;
  assign in_vec.y  = in_ch.vec_y;
  assign in_vec.z  = in_ch.vec_z;

  // First Hamilton product: products, then three-term sums.
  vrq_ham1 u_ham1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_quat   (in_quat),
    .in_vec    (in_vec),
    .out_valid (h1_valid),
    .out_ready (h1_ready),
    .out_p     (h1_p),
    .out_q     (h1_q)
  );

  // Second product with conj(q): split multiplies, then signed sums.
  vrq_ham2 u_ham2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h1_valid),
    .in_ready  (h1_ready),
    .in_p      (h1_p),
    .in_q      (h1_q),
    .out_valid (h2_valid),
    .out_ready (h2_ready),
    .out_parts (h2_parts)
  );

  // Recombine, round, saturate; its last stage is the output register.
  vrq_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h2_valid),
    .in_ready  (h2_ready),
    .in_parts  (h2_parts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rot   (rot)
  );

  assign out_ch.rot_x     = rot.x;
  assign out_ch.rot_y     = rot.y;
  assign out_ch.rot_z     = rot.z;
  assign out_ch.saturated = rot.sat;

  // A clipped item carries at least one rail value.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.rot_x == SAT_POS || out_ch.rot_x == SAT_NEG ||
       out_ch.rot_y == SAT_POS || out_ch.rot_y == SAT_NEG ||
       out_ch.rot_z == SAT_POS || out_ch.rot_z == SAT_NEG))
    else $error("saturated flag without a clipped component");

  // Input back-pressure only arises behind a waiting result.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled while the output side can move");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
